// File: design/observer_state_feedback_servo_defines.svh
// Assertion macros for the observer state-feedback servo.
// No dependencies; included by files that carry concurrent assertions.
`ifndef OBSERVER_STATE_FEEDBACK_SERVO_DEFINES_SVH
`define OBSERVER_STATE_FEEDBACK_SERVO_DEFINES_SVH

// ante implies cons in the same cycle
`define OSFS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define OSFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// bad never holds
`define OSFS_ASSERT_NEVER(label, clk, rst_n, bad, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
        else $error(msg);

`endif

// File: design/osfs_pkg.sv
// Shared widths, gains, codes and helper functions for the servo.
// No dependencies; used by every module of the servo.
package osfs_pkg;

    localparam int FRACTION_BITS_DEF = 13;

    localparam int POS_W    = 10;
    localparam int REF_W    = 11;
    localparam int TPS_W    = 8;
    localparam int DRIVE_W  = 10;
    localparam int STATE_W  = 16;
    localparam int OPND_W   = 17;
    localparam int CONST_W  = 15;
    localparam int ACC_W    = 34;
    localparam int CNT_W    = $clog2(OPND_W + 1);

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CONST_W-1:0] GAIN_REF = 15'd14607;
    localparam logic [CONST_W-1:0] GAIN_X1  = 15'd26950;
    localparam logic [CONST_W-1:0] GAIN_X2  = 15'd14607;
    localparam logic [CONST_W-1:0] PHI_11   = 15'd8143;
    localparam logic [CONST_W-1:0] PHI_21   = 15'd2042;
    localparam logic [CONST_W-1:0] PHI_22   = 15'd8192;
    localparam logic [CONST_W-1:0] GAM_1    = 15'd919;
    localparam logic [CONST_W-1:0] GAM_2    = 15'd115;
    localparam logic [CONST_W-1:0] OBS_L1   = 15'd16680;
    localparam logic [CONST_W-1:0] OBS_L2   = 15'd10191;
    localparam logic [CONST_W-1:0] OBS_L3   = 15'd26293;

    localparam logic signed [STATE_W-1:0] DRIVE_MAX = 16'sd511;
    localparam logic signed [STATE_W-1:0] DRIVE_MIN = -16'sd512;
    localparam logic [DRIVE_W-1:0]        PWM_OFFSET = 10'd512;

    localparam logic [REF_W-1:0] REFERENCE_RST = 11'd255;
    localparam logic [TPS_W-1:0] TPS_RST       = 8'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE    = 2'd0,
        CFG_REFERENCE = 2'd1,
        CFG_TICKS     = 2'd2
    } cfg_index_t;

    // One serial product per term, in evaluation order.
    typedef enum logic [3:0] {
        TERM_REF,
        TERM_X1,
        TERM_X2,
        TERM_S1_X1,
        TERM_S1_W,
        TERM_S1_E,
        TERM_S2_X1,
        TERM_S2_X2,
        TERM_S2_W,
        TERM_S2_E,
        TERM_V_E
    } term_t;

    typedef enum logic [2:0] {
        SRC_REF,
        SRC_X1,
        SRC_X2,
        SRC_W,
        SRC_E
    } opnd_src_t;

    typedef struct packed {
        logic start;
        logic clear;
    } mac_ctrl_t;

    typedef struct packed {
        logic idle;
        logic result_valid;
    } seq_status_t;

    function automatic logic [CONST_W-1:0] term_coef(input term_t t);
        logic [CONST_W-1:0] c;
        unique case (t)
            TERM_REF:   c = GAIN_REF;
            TERM_X1:    c = GAIN_X1;
            TERM_X2:    c = GAIN_X2;
            TERM_S1_X1: c = PHI_11;
            TERM_S1_W:  c = GAM_1;
            TERM_S1_E:  c = OBS_L1;
            TERM_S2_X1: c = PHI_21;
            TERM_S2_X2: c = PHI_22;
            TERM_S2_W:  c = GAM_2;
            TERM_S2_E:  c = OBS_L2;
            TERM_V_E:   c = OBS_L3;
            default:    c = '0;
        endcase
        return c;
    endfunction

    function automatic opnd_src_t term_src(input term_t t);
        opnd_src_t s;
        unique case (t)
            TERM_REF:                           s = SRC_REF;
            TERM_X1, TERM_S1_X1, TERM_S2_X1:    s = SRC_X1;
            TERM_X2, TERM_S2_X2:                s = SRC_X2;
            TERM_S1_W, TERM_S2_W:               s = SRC_W;
            default:                            s = SRC_E;
        endcase
        return s;
    endfunction

    // Terms that start a fresh sum
    function automatic logic term_clear(input term_t t);
        logic c;
        unique case (t)
            TERM_REF, TERM_X1, TERM_X2,
            TERM_S1_X1, TERM_S2_X1, TERM_V_E: c = 1'b1;
            default:                          c = 1'b0;
        endcase
        return c;
    endfunction

endpackage

// File: design/osfs_serial_mac.sv
// Bit-serial multiply-accumulate: signed operand times unsigned gain,
// one operand bit per cycle, LSB first. Depends on osfs_pkg.
module osfs_serial_mac
    import osfs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mac_ctrl_t                 ctrl,
    input  logic [OPND_W-1:0]         operand,
    input  logic [CONST_W-1:0]        coef,
    output logic signed [ACC_W-1:0]   acc,
    output logic                      done
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [ACC_W-1:0]        mcand_reg;
    logic [OPND_W-1:0]       mplier_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    last_bit;

    assign last_bit = (cnt_reg == CNT_W'(OPND_W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            if (ctrl.clear)
            begin
                acc_next = '0;
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            // sign bit carries negative weight
            if (mplier_reg[0])
            begin
                acc_next = last_bit ? acc_reg - $signed(mcand_reg)
                                    : acc_reg + $signed(mcand_reg);
            end
            if (last_bit)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (ctrl.start)
        begin
            mcand_reg  <= {{(ACC_W - CONST_W){1'b0}}, coef};
            mplier_reg <= operand;
        end
        else if (busy_reg)
        begin
            mcand_reg  <= {mcand_reg[ACC_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[OPND_W-1:1]};
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// File: design/osfs_step_seq.sv
// Control-step sequencer: walks the eleven gain products through the
// serial MAC, forms the drive and updates observer and integral state.
// Depends on osfs_pkg and osfs_serial_mac.
module osfs_step_seq
    import osfs_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      ack,
    input  logic signed [REF_W-1:0]   reference,
    input  logic signed [POS_W-1:0]   position,
    output seq_status_t               status,
    output logic signed [DRIVE_W-1:0] drive
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_POST,
        S_DONE
    } seq_state_t;

    seq_state_t                state_reg;
    term_t                     term_reg;
    logic signed [STATE_W-1:0] raw_reg;
    logic signed [DRIVE_W-1:0] u_reg;
    logic signed [OPND_W-1:0]  w_reg;
    logic signed [STATE_W-1:0] e_reg;
    logic signed [STATE_W-1:0] x1_reg;
    logic signed [STATE_W-1:0] x2_reg;
    logic signed [STATE_W-1:0] v_reg;
    logic signed [STATE_W-1:0] x1n_reg;

    mac_ctrl_t                 mac_ctrl;
    logic [OPND_W-1:0]         operand;
    logic signed [ACC_W-1:0]   mac_acc;
    logic                      mac_done;
    logic signed [ACC_W-1:0]   acc_shift;
    logic signed [STATE_W-1:0] asr16;
    logic signed [STATE_W-1:0] raw_fin;
    logic signed [DRIVE_W-1:0] u_clamp;
    logic signed [STATE_W-1:0] pos_ext;

    assign mac_ctrl.start = (state_reg == S_START);
    assign mac_ctrl.clear = term_clear(term_reg);

    always_comb
    begin
        unique case (term_src(term_reg))
            SRC_REF: operand = {{(OPND_W - REF_W){reference[REF_W-1]}}, reference};
            SRC_X1:  operand = {x1_reg[STATE_W-1], x1_reg};
            SRC_X2:  operand = {x2_reg[STATE_W-1], x2_reg};
            SRC_W:   operand = w_reg;
            SRC_E:   operand = {e_reg[STATE_W-1], e_reg};
            default: operand = '0;
        endcase
    end

    osfs_serial_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .operand (operand),
        .coef    (term_coef(term_reg)),
        .acc     (mac_acc),
        .done    (mac_done)
    );

    // floor shift of the exact sum, then keep 16 bits
    assign acc_shift = mac_acc >>> FRACTION_BITS;
    assign asr16     = acc_shift[STATE_W-1:0];

    assign raw_fin = raw_reg - asr16 - v_reg;
    assign pos_ext = {{(STATE_W - POS_W){position[POS_W-1]}}, position};

    always_comb
    begin
        priority if (raw_fin > DRIVE_MAX)
        begin
            u_clamp = DRIVE_MAX[DRIVE_W-1:0];
        end
        else if (raw_fin < DRIVE_MIN)
        begin
            u_clamp = DRIVE_MIN[DRIVE_W-1:0];
        end
        else
        begin
            u_clamp = raw_fin[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            term_reg  <= TERM_REF;
            raw_reg   <= '0;
            u_reg     <= '0;
            w_reg     <= '0;
            e_reg     <= '0;
            x1_reg    <= '0;
            x2_reg    <= '0;
            v_reg     <= '0;
            x1n_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        term_reg  <= TERM_REF;
                        state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (mac_done)
                    begin
                        state_reg <= S_POST;
                    end
                end
                S_POST:
                begin
                    unique case (term_reg)
                        TERM_REF:
                        begin
                            raw_reg <= asr16;
                        end
                        TERM_X1:
                        begin
                            raw_reg <= raw_reg - asr16;
                        end
                        TERM_X2:
                        begin
                            u_reg <= u_clamp;
                            w_reg <= {v_reg[STATE_W-1], v_reg}
                                   + {{(OPND_W - DRIVE_W){u_clamp[DRIVE_W-1]}}, u_clamp};
                            e_reg <= pos_ext - x2_reg;
                        end
                        TERM_S1_E:
                        begin
                            x1n_reg <= asr16;
                        end
                        TERM_S2_E:
                        begin
                            // old x1 and x2 are no longer needed
                            x1_reg <= x1n_reg;
                            x2_reg <= asr16;
                        end
                        TERM_V_E:
                        begin
                            v_reg <= v_reg + asr16;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (term_reg == TERM_V_E)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        term_reg  <= term_t'(term_reg + 1'b1);
                        state_reg <= S_START;
                    end
                end
                S_DONE:
                begin
                    if (ack)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign status.idle         = (state_reg == S_IDLE);
    assign status.result_valid = (state_reg == S_DONE);
    assign drive               = u_reg;

endmodule

// File: design/observer_state_feedback_servo.sv
// An enabled step runs through the sequencer; a disabled step sets the pending flag. Either
// result enters the output register once the slot frees. Samples are taken one tick per cycle
// while no step is running or waiting; a step holds off new samples until its result is loaded,
// paced by the one serial MAC that forms all eleven gain products one operand bit a cycle.
// Reset (rst_n, async, low): observer, integral and tick count clear; enable 0,
// reference 255, ticks_per_step 5; no transaction pending.
module observer_state_feedback_servo
    import osfs_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // sample stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // [9:0] measured_position, rest zero
    // result stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // [9:0] drive, [19:10] pwm_compare
    output logic                    m_axis_tuser,   // [0] running
    // register writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

`include "observer_state_feedback_servo_defines.svh"

    // configuration
    logic                      enable_reg;
    logic signed [REF_W-1:0]   reference_reg;
    logic [TPS_W-1:0]          tps_reg;

    // tick divider and sample hold
    logic [TPS_W-1:0]          tick_count_reg;
    logic [TPS_W:0]            tick_next9;
    logic                      step_now;
    logic signed [POS_W-1:0]   pos_reg;

    // disabled step waiting for the output register
    logic                      dis_pend_reg;

    // output register
    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_out_reg;
    logic                      running_reg;
    logic [DRIVE_W-1:0]        pwm_out;

    seq_status_t               seq_status;
    logic signed [DRIVE_W-1:0] seq_drive;
    logic                      seq_start;
    logic                      seq_ack;
    logic                      in_accept;
    logic                      result_ready;
    logic                      slot_free;
    logic                      out_load;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = seq_status.idle && !dis_pend_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Step when count+1 reaches the period; a period of zero steps every tick.
    assign tick_next9 = {1'b0, tick_count_reg} + 1'b1;
    assign step_now   = (tick_next9 >= {1'b0, tps_reg});
    assign seq_start  = in_accept && step_now && enable_reg;

    // The output register is parted from the sequencer: a result waits
    // in the sequencer (or as the pending flag) until the slot frees.
    assign result_ready = seq_status.result_valid || dis_pend_reg;
    assign slot_free    = !out_valid_reg || m_axis_tready;
    assign out_load     = result_ready && slot_free;
    assign seq_ack      = out_load && seq_status.result_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            reference_reg <= REFERENCE_RST;
            tps_reg       <= TPS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENABLE:    enable_reg    <= cfg_data[0];
                CFG_REFERENCE: reference_reg <= cfg_data;
                CFG_TICKS:     tps_reg       <= cfg_data[TPS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            dis_pend_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            running_reg    <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                tick_count_reg <= step_now ? '0 : tick_next9[TPS_W-1:0];
            end

            if (in_accept && step_now && !enable_reg)
            begin
                dis_pend_reg <= 1'b1;
            end
            else if (out_load)
            begin
                dis_pend_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                running_reg   <= !dis_pend_reg;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pos_reg <= s_axis_tdata[POS_W-1:0];
        end
        if (out_load)
        begin
            drive_out_reg <= dis_pend_reg ? '0 : seq_drive;
        end
    end

    osfs_step_seq #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (seq_start),
        .ack       (seq_ack),
        .reference (reference_reg),
        .position  (pos_reg),
        .status    (seq_status),
        .drive     (seq_drive)
    );

    assign pwm_out       = drive_out_reg + PWM_OFFSET;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2 * DRIVE_W){1'b0}}, pwm_out, drive_out_reg};
    assign m_axis_tuser  = running_reg;

    `OSFS_ASSERT_NEVER(a_pend_while_busy, clk, rst_n,
        dis_pend_reg && !seq_status.idle, "disabled step pending while sequencer busy")
    `OSFS_ASSERT_NEXT(a_start_busy, clk, rst_n, seq_start,
        !seq_status.idle && !dis_pend_reg, "enabled step did not start the sequencer")
    `OSFS_ASSERT_NEXT(a_dis_no_seq, clk, rst_n, in_accept && step_now && !enable_reg,
        seq_status.idle && dis_pend_reg, "disabled step started the sequencer")
    `OSFS_ASSERT_IMPLIES(a_idle_drive, clk, rst_n, m_axis_tvalid && !m_axis_tuser,
        drive_out_reg == '0, "disabled result with nonzero drive")

endmodule

// File: verif/testbench.sv
// Self-checking bench for observer_state_feedback_servo: samples, register writes, drive check.
// Depends on osfs_pkg and the observer_state_feedback_servo RTL.
module testbench;
    import osfs_pkg::*;

    localparam int FRAC = FRACTION_BITS_DEF;

    // servo gains, Q13
    localparam longint K_REF = 14607;
    localparam longint K_X1  = 26950;
    localparam longint K_X2  = 14607;
    localparam longint K_P11 = 8143;
    localparam longint K_P21 = 2042;
    localparam longint K_P22 = 8192;
    localparam longint K_G1  = 919;
    localparam longint K_G2  = 115;
    localparam longint K_L1  = 16680;
    localparam longint K_L2  = 10191;
    localparam longint K_L3  = 26293;

    localparam int STEP_CYCLES   = 11 * (OPND_W + 3) + 40;  // one control step plus margin
    localparam int HOLD_CYCLES   = 1200;
    localparam int STALL_LIMIT   = 20000;
    localparam int MAX_SHOWN     = 10;
    localparam int PHASES        = 14;
    localparam int PHASE_SAMPLES = 134;

    typedef struct {
        logic signed [DRIVE_W-1:0] drive;
        logic [DRIVE_W-1:0]        pwm;
        logic                      running;
    } servo_out_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;     // [9:0] measured_position
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;          // [9:0] drive, [19:10] pwm_compare
    logic                   m_axis_tuser;          // [0] running
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_ENABLE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    observer_state_feedback_servo dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // servo predictor: register copies and state
    logic                      set_enable = 1'b0;
    logic signed [REF_W-1:0]   set_reference = 11'sd255;
    logic [TPS_W-1:0]          set_ticks = 8'd5;
    logic [TPS_W-1:0]          tick_cnt = '0;
    logic signed [STATE_W-1:0] obs_x1 = '0;
    logic signed [STATE_W-1:0] obs_x2 = '0;
    logic signed [STATE_W-1:0] integ_v = '0;

    servo_out_t          drives_due[$];       // predicted results, oldest first
    logic [POS_W-1:0]    samples_pending[$];  // samples not yet offered

    int   send_idle_pct = 20;
    int   recv_idle_pct = 69;
    int   holds_asked = 0;
    int   holds_done = 0;
    int   hold_left = 0;
    int   mismatches = 0;
    int   quiet_cycles = 0;
    int   track_pos = 0;
    logic sample_taken = 1'b0;

    // One timer tick; queues a result when the tick runs a control step.
    function automatic void servo_tick(input logic signed [POS_W-1:0] y);
        int unsigned               nxt;
        longint                    r, x1, x2, v, raw, u, e, w, s1, s2;
        logic signed [STATE_W-1:0] u16, e16;
        servo_out_t                o;
        nxt = tick_cnt + 1;
        if (nxt < set_ticks) begin
            tick_cnt = nxt[TPS_W-1:0];
            return;
        end
        tick_cnt = '0;
        if (!set_enable) begin
            o.drive = '0;
            o.pwm = PWM_OFFSET;
            o.running = 1'b0;
            drives_due.push_back(o);
            return;
        end
        r  = set_reference;
        x1 = obs_x1;
        x2 = obs_x2;
        v  = integ_v;
        raw = ((K_REF * r) >>> FRAC) - ((K_X1 * x1) >>> FRAC) - ((K_X2 * x2) >>> FRAC) - v;
        u16 = raw[STATE_W-1:0];
        u = u16;
        if (u > 511)
            u = 511;
        else if (u < -512)
            u = -512;
        o.drive = u[DRIVE_W-1:0];
        w = u + 512;
        o.pwm = w[DRIVE_W-1:0];
        o.running = 1'b1;
        drives_due.push_back(o);

        // observer and integrator update from the output error
        e = y;
        e = e - x2;
        e16 = e[STATE_W-1:0];
        e = e16;
        w = u + v;
        s1 = K_P11 * x1 + K_G1 * w + K_L1 * e;
        s2 = K_P21 * x1 + K_P22 * x2 + K_G2 * w + K_L2 * e;
        s1 = s1 >>> FRAC;
        s2 = s2 >>> FRAC;
        v = v + ((K_L3 * e) >>> FRAC);
        obs_x1 = s1[STATE_W-1:0];
        obs_x2 = s2[STATE_W-1:0];
        integ_v = v[STATE_W-1:0];
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Register write; the predictor copy follows at the accepting edge.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_ENABLE:    set_enable = val[0];
            CFG_REFERENCE: set_reference = val;
            CFG_TICKS:     set_ticks = val[TPS_W-1:0];
            default:       ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_sample(input int p);
        samples_pending.push_back(p[POS_W-1:0]);
    endtask

    // Mostly a slow random walk, with full-range values and extremes mixed in.
    function automatic int next_position();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return $urandom_range(1) ? 511 : -512;
        if (pick < 35)
            return int'($urandom_range(1023)) - 512;
        track_pos = track_pos + int'($urandom_range(64)) - 32;
        if (track_pos > 511)
            track_pos = 511;
        if (track_pos < -512)
            track_pos = -512;
        return track_pos;
    endfunction

    // Wait until every sample is in and every result is out, then a tail.
    task automatic settle(input int tail);
        while (samples_pending.size() != 0 || s_axis_tvalid || drives_due.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    initial begin
        forever #5 clk = ~clk;
    end

    // sample driver
    always @(negedge clk) begin
        if (!s_axis_tvalid || sample_taken) begin
            if (samples_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tdata <= samples_pending.pop_front();
                s_axis_tvalid <= 1'b1;
            end else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result receiver, with long hold-offs on request
    always @(negedge clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_asked != holds_done) begin
            holds_done <= holds_done + 1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: predict on accepted samples, check accepted results
    always @(posedge clk) begin : monitor
        servo_out_t due;
        sample_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            servo_tick(s_axis_tdata[POS_W-1:0]);
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (drives_due.size() == 0)
                note_mismatch($sformatf("unexpected result, drive %0d running %0b",
                    $signed(m_axis_tdata[DRIVE_W-1:0]), m_axis_tuser));
            else begin
                due = drives_due.pop_front();
                if (m_axis_tdata[DRIVE_W-1:0] != due.drive)
                    note_mismatch($sformatf("drive expected %0d, got %0d",
                        due.drive, $signed(m_axis_tdata[DRIVE_W-1:0])));
                if (m_axis_tdata[2*DRIVE_W-1:DRIVE_W] != due.pwm)
                    note_mismatch($sformatf("pwm_compare expected %0d, got %0d",
                        due.pwm, m_axis_tdata[2*DRIVE_W-1:DRIVE_W]));
                if (m_axis_tuser != due.running)
                    note_mismatch($sformatf("running expected %0b, got %0b",
                        due.running, m_axis_tuser));
            end
        end
    end

    // watchdog: cycles with no transaction on any channel
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("** observer_state_feedback_servo: FAILED **");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : stimulus
        int ph;
        int i;
        int ref_val;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: disabled, five ticks per step
        queue_sample(511);
        queue_sample(-512);
        queue_sample(0);
        queue_sample(-1);
        queue_sample(1);
        settle(8);

        // enabled, full positive reference, a step on every tick
        write_reg(CFG_ENABLE, 11'd1);
        write_reg(CFG_REFERENCE, 11'd1023);
        write_reg(CFG_TICKS, 11'd1);
        queue_sample(-512);
        queue_sample(511);
        queue_sample(0);
        queue_sample(-1);
        queue_sample(1);
        queue_sample(341);
        queue_sample(-342);
        queue_sample(511);
        queue_sample(511);
        settle(8);

        // zero period behaves as one; negative reference of -1023
        write_reg(CFG_REFERENCE, 11'h401);
        write_reg(CFG_TICKS, 11'd0);
        queue_sample(511);
        queue_sample(-512);
        queue_sample(100);
        settle(8);

        // period lowered below the running count: next tick steps
        write_reg(CFG_REFERENCE, 11'd0);
        write_reg(CFG_TICKS, 11'd4);
        queue_sample(7);
        queue_sample(-7);
        queue_sample(200);
        settle(8);
        write_reg(CFG_TICKS, 11'd2);
        queue_sample(-300);
        settle(8);

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph == 5) begin
                send_idle_pct = 69;
                recv_idle_pct = 20;
            end
            if (ph == 10) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 1 || ph == 2 || $urandom_range(3) != 0)
                write_reg(CFG_ENABLE, (ph == 1) ? 11'd0 : 11'(($urandom_range(7) != 0)));
            if ($urandom_range(3) != 0) begin
                case ($urandom_range(4))
                    0:       ref_val = 1023;
                    1:       ref_val = -1023;
                    default: ref_val = int'($urandom_range(2046)) - 1023;
                endcase
                write_reg(CFG_REFERENCE, ref_val[CFG_DATA_W-1:0]);
            end
            if (ph == 7)
                write_reg(CFG_TICKS, 11'd255);
            else if (ph == 8 || $urandom_range(3) != 0)
                write_reg(CFG_TICKS, 11'($urandom_range(1, 6)));
            for (i = 0; i < PHASE_SAMPLES; i++)
                queue_sample(next_position());
            // receiver backs off while samples keep coming; input must stall
            if (ph == 3 || ph == 11)
                holds_asked++;
            settle(8);
        end

        settle(STEP_CYCLES);
        if (mismatches == 0)
            $display("** observer_state_feedback_servo: PASSED **");
        else
            $display("** observer_state_feedback_servo: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/osfs_pkg.sv
design/osfs_serial_mac.sv
design/osfs_step_seq.sv
design/observer_state_feedback_servo.sv
verif/testbench.sv
